/* rtl/pcp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcp_pkg
// Shared constants, types and tables for the polar/cartesian projector.
// ----------------------------------------------------------------------------
package pcp_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int NSTG = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
    localparam int XW = 66;

    localparam logic [1:0] OP_P2C  = 2'd0;
    localparam logic [1:0] OP_C2P  = 2'd1;
    localparam logic [1:0] OP_PROJ = 2'd2;
    localparam logic [1:0] OP_RSVD = 2'd3;

    localparam logic [31:0] KINV = 32'h9B74EDA8;
    localparam logic [31:0] HALF_TURN = 32'h80000000;
    localparam logic [31:0] QUARTER_TURN = 32'h40000000;

    // CORDIC lane: rotation when vec is low, vectoring when high
    typedef struct packed {
        logic             vec;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [33:0] z;
    } lane_t;

    // side information carried along the CORDIC
    typedef struct packed {
        logic [1:0] op;
        logic       zero;
    } side_t;

    function automatic logic [31:0] atan_turn(input int i);
        logic [31:0] t [32];
        t = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
              32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
              32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
              32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
              32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
              32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
              32'h00000001, 32'h00000000};
        return t[i[4:0]];
    endfunction

    // saturate a signed wide value to 32 bits
    function automatic logic [32:0] clip32(input logic signed [XW-1:0] v);
        logic [32:0] r;
        if (v > 66'sd2147483647) r = {1'b1, 32'h7FFFFFFF};
        else if (v < -66'sd2147483648) r = {1'b1, 32'h80000000};
        else r = {1'b0, v[31:0]};
        return r;
    endfunction

endpackage

/* rtl/polar_cartesian_projector.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polar_cartesian_projector
// Pipelined CORDIC geometry unit: polar/cartesian conversion and frame
// projection.
// ----------------------------------------------------------------------------
// One transfer in, one out, one item per cycle sustained. The pipe holds
// a seed stage, one stage per CORDIC micro-rotation, a rounding stage,
// one stage for the gain/projection multipliers and the output register.
// A low m_axis_tready while a result waits stalls the whole pipe.
module polar_cartesian_projector
    import pcp_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // coord_x[31:0], coord_y[63:32], angle[79:64], module_req[111:80],
    // frame_angle[127:112]
    input  logic [127:0] s_axis_tdata,
    // operation[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // rot_x, rot_y, axis_x_proj_x, axis_x_proj_y, axis_y_proj_x,
    // axis_y_proj_y, angle_out[207:192], module_out[239:208]
    output logic [239:0] m_axis_tdata,
    // saturated[0]
    output logic         m_axis_tuser
);

    localparam int D = NSTG + 4;

    logic en;
    logic [D-1:0] vld_reg;
    assign en = m_axis_tready | ~m_axis_tvalid;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[D-1];

    // valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) vld_reg <= '0;
        else if (en) vld_reg <= {vld_reg[D-2:0], s_axis_tvalid};
    end

    logic [1:0]  op;
    logic signed [31:0] cx, cy;
    logic [15:0] ang, fr, a;
    logic [31:0] mag;
    assign op  = s_axis_tuser;
    assign cx  = s_axis_tdata[31:0];
    assign cy  = s_axis_tdata[63:32];
    assign ang = s_axis_tdata[79:64];
    assign mag = s_axis_tdata[111:80];
    assign fr  = s_axis_tdata[127:112];
    assign a   = (op == OP_P2C) ? ang : 16'(ang - fr);

    function automatic lane_t seed_rot(input logic [31:0] m, input logic [15:0] t16);
        lane_t l;
        logic [31:0] t;
        logic signed [XW-1:0] x;
        t = {t16, 16'h0};
        x = $signed(XW'(({32'h0, m} * {32'h0, KINV}) >> 16));
        if (32'(t - QUARTER_TURN) < HALF_TURN) begin
            x = -x; t = t - HALF_TURN;
        end
        l.vec = 1'b0; l.x = x; l.y = '0;
        l.z = $signed({{2{t[31]}}, t});
        return l;
    endfunction

    // seed stage
    lane_t a0_reg, b0_reg;
    side_t s_reg [NSTG+3];
    always_ff @(posedge aclk) begin
        if (en) begin
            s_reg[0].op <= op;
            s_reg[0].zero <= (cx == 0) && (cy == 0);
            b0_reg <= seed_rot(32'h10000, fr);
            if (op == OP_C2P) begin
                a0_reg.vec <= 1'b1;
                a0_reg.x <= cx[31] ? -(XW'(cx) <<< 16) : (XW'(cx) <<< 16);
                a0_reg.y <= cx[31] ? -(XW'(cy) <<< 16) : (XW'(cy) <<< 16);
                a0_reg.z <= cx[31] ? 34'sh080000000 : '0;
            end else begin
                a0_reg <= seed_rot(mag, a);
            end
        end
    end

    lane_t al [NSTG+1];
    lane_t bl [NSTG+1];
    assign al[0] = a0_reg;
    assign bl[0] = b0_reg;

    for (genvar i = 0; i < NSTG; i++) begin : g_stg
        pcp_cordic_stage u_stg (
            .aclk(aclk), .en(en), .stage_idx(5'(i)), .a_in(al[i]), .b_in(bl[i]),
            .a_out(al[i+1]), .b_out(bl[i+1]));
        always_ff @(posedge aclk) begin
            if (en) begin
                s_reg[i+1] <= s_reg[i];
            end
        end
    end

    // rounding stage
    logic signed [31:0] rx_reg, ry_reg;
    logic signed [31:0] c_reg, sn_reg;
    logic [15:0] ao_reg;
    logic [XW-1:0] ux_reg;
    logic sat1_reg;
    logic signed [XW-1:0] rxw, ryw, cw, sw;
    logic [32:0] crx, cry;
    logic [31:0] zw;
    assign rxw = (al[NSTG].x + 66'sh8000) >>> 16;
    assign ryw = (al[NSTG].y + 66'sh8000) >>> 16;
    // unit lane is already at 2^32 scale: one shift by 2 gives Q1.30
    assign cw  = (bl[NSTG].x + 66'sd2) >>> 2;
    assign sw  = (bl[NSTG].y + 66'sd2) >>> 2;
    assign crx = clip32(rxw);
    assign cry = clip32(ryw);
    assign zw  = 32'(al[NSTG].z) + 32'h8000;
    always_ff @(posedge aclk) begin
        if (en) begin
            s_reg[NSTG+1] <= s_reg[NSTG];
            rx_reg <= crx[31:0];
            ry_reg <= cry[31:0];
            sat1_reg <= crx[32] | cry[32];
            c_reg <= cw[31:0];
            sn_reg <= sw[31:0];
            ao_reg <= zw[31:16];
            ux_reg <= al[NSTG].x[XW-1] ? '0 : al[NSTG].x;
        end
    end

    // multiply stage
    logic signed [63:0] pxc_reg, pxs_reg, pys_reg, pyc_reg;
    logic [63:0] mh_reg, ml_reg;
    logic signed [31:0] rx2_reg, ry2_reg;
    logic [15:0] ao2_reg;
    logic sat2_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            s_reg[NSTG+2] <= s_reg[NSTG+1];
            pxc_reg <= rx_reg * c_reg;
            pxs_reg <= rx_reg * sn_reg;
            pys_reg <= ry_reg * sn_reg;
            pyc_reg <= ry_reg * c_reg;
            mh_reg <= {32'h0, ux_reg[63:32]} * {32'h0, KINV};
            ml_reg <= {32'h0, ux_reg[31:0]} * {32'h0, KINV};
            rx2_reg <= rx_reg; ry2_reg <= ry_reg;
            ao2_reg <= ao_reg; sat2_reg <= sat1_reg;
        end
    end

    // round and saturate products
    logic [32:0] q0, q1, q2, q3;
    logic [XW-1:0] tm, mm;
    assign q0 = clip32((XW'(pxc_reg) + 66'sh20000000) >>> 30);
    assign q1 = clip32((XW'(pxs_reg) + 66'sh20000000) >>> 30);
    assign q2 = clip32((-XW'(pys_reg) + 66'sh20000000) >>> 30);
    assign q3 = clip32((XW'(pyc_reg) + 66'sh20000000) >>> 30);
    assign tm = XW'(mh_reg) + XW'(ml_reg[63:32]);
    assign mm = (tm + 66'h8000) >> 16;

    // select the result fields for the operation
    logic [240:0] res_next;
    logic [240:0] res_reg;
    always_comb begin
        res_next = '0;
        unique case (s_reg[NSTG+2].op)
            OP_P2C: begin
                res_next[63:0] = {ry2_reg, rx2_reg};
                res_next[240] = sat2_reg;
            end
            OP_PROJ: begin
                res_next[191:0] = {q3[31:0], q2[31:0], q1[31:0], q0[31:0],
                                   ry2_reg, rx2_reg};
                res_next[240] = sat2_reg | q0[32] | q1[32] | q2[32] | q3[32];
            end
            OP_C2P: begin
                if (!s_reg[NSTG+2].zero) begin
                    res_next[207:192] = ao2_reg;
                    res_next[239:208] = (mm > 66'hFFFFFFFF) ? 32'hFFFFFFFF
                                                           : mm[31:0];
                    res_next[240] = mm > 66'hFFFFFFFF;
                end
            end
            OP_RSVD: ;
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg <= res_next;
        end
    end

    assign m_axis_tdata = res_reg[239:0];
    assign m_axis_tuser = res_reg[240];

endmodule

/* rtl/pcp_cordic_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcp_cordic_stage
// One registered CORDIC micro-rotation for two lanes (main and unit vector).
// ----------------------------------------------------------------------------
module pcp_cordic_stage
    import pcp_pkg::*;
(
    input  logic       aclk,
    input  logic       en,
    input  logic [4:0] stage_idx,
    input  lane_t      a_in,
    input  lane_t      b_in,
    output lane_t      a_out,
    output lane_t      b_out
);

    function automatic lane_t step(input lane_t l, input logic [4:0] sh);
        lane_t r;
        logic  up;
        logic signed [XW-1:0] dx, dy;
        logic [31:0] at;
        at = atan_turn(int'(sh));
        dx = l.y >>> sh;
        dy = l.x >>> sh;
        up = l.vec ? !l.y[XW-1] : !l.z[33];
        r = l;
        if (up ^ l.vec) begin
            r.x = l.x - dx; r.y = l.y + dy;
        end else begin
            r.x = l.x + dx; r.y = l.y - dy;
        end
        if (up) r.z = l.z - $signed({2'b0, at});
        else    r.z = l.z + $signed({2'b0, at});
        if (l.vec) r.z = up ? l.z + $signed({2'b0, at})
                            : l.z - $signed({2'b0, at});
        return r;
    endfunction

    // advance both lanes when the pipe moves
    always_ff @(posedge aclk) begin
        if (en) begin
            a_out <= step(a_in, stage_idx);
            b_out <= step(b_in, stage_idx);
        end
    end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the polar/cartesian projector: directed vectors
// and random traffic for all operations, checked transfer by transfer
// against a bit-exact CORDIC predictor or typed-in results, under several stall/idle phases.
// ----------------------------------------------------------------------------
module testbench
    import pcp_pkg::*;
;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] cx;
        logic [31:0] cy;
        logic [15:0] ang;
        logic [31:0] mag;
        logic [15:0] fr;
    } geo_req_t;

    typedef struct packed {
        logic [31:0] rot_x;
        logic [31:0] rot_y;
        logic [31:0] axp_x;
        logic [31:0] axp_y;
        logic [31:0] ayp_x;
        logic [31:0] ayp_y;
        logic [15:0] ang_out;
        logic [31:0] mod_out;
        logic        sat;
    } geo_res_t;

    // directed row: request plus an optional typed-in result
    typedef struct {
        geo_req_t req;
        bit       has_res;
        geo_res_t res;
    } vec_row_t;

    localparam int LATENCY = NSTG + 4;
    localparam longint I32MAX = 64'sd2147483647;
    localparam longint I32MIN = -64'sd2147483648;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata = '0;
    logic [1:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [239:0] m_axis_tdata;
    logic         m_axis_tuser;

    geo_res_t expected_q[$];
    int       n_mismatch = 0;
    int       n_results = 0;
    int       n_sent = 0;
    int       sender_idle_pct = 0;
    int       recv_stall_pct = 0;
    int       hold_cycles = 0;

    polar_cartesian_projector i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic longint fshr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint sat32(longint v, ref bit flag);
        if (v > I32MAX) begin
            flag = 1;
            return I32MAX;
        end
        if (v < I32MIN) begin
            flag = 1;
            return I32MIN;
        end
        return v;
    endfunction

    // rotation mode: magnitude at a 32-bit turn fraction
    function automatic void cordic_rotate(input logic [31:0] mag,
                                          input logic [31:0] turn,
                                          output longint xo, output longint yo);
        longint x, y, z, dx, dy;
        logic [31:0] t;
        x = longint'((64'(mag) * 64'(KINV)) >> 16);
        y = 0;
        t = turn;
        if (t - QUARTER_TURN < HALF_TURN) begin
            x = -x;
            t = t - HALF_TURN;
        end
        z = longint'(signed'(t));
        for (int i = 0; i < NSTG; i++) begin
            dx = fshr(y, i);
            dy = fshr(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(atan_turn(i));
            end else begin
                x += dx; y -= dy; z += longint'(atan_turn(i));
            end
        end
        xo = x;
        yo = y;
    endfunction

    function automatic geo_res_t predict_geometry(geo_req_t q);
        geo_res_t r;
        bit sat;
        longint x, y, rx, ry, c, s, dx, dy;
        logic [15:0] a;
        logic [31:0] z;
        logic [63:0] ux, t, m;
        r = '0;
        sat = 0;
        if (q.op == OP_P2C || q.op == OP_PROJ) begin
            a = (q.op == OP_P2C) ? q.ang : q.ang - q.fr;
            cordic_rotate(q.mag, {a, 16'h0}, x, y);
            rx = sat32(fshr(x + 32768, 16), sat);
            ry = sat32(fshr(y + 32768, 16), sat);
            r.rot_x = rx[31:0];
            r.rot_y = ry[31:0];
            if (q.op == OP_PROJ) begin
                cordic_rotate(32'h10000, {q.fr, 16'h0}, c, s);
                c = fshr(c + 2, 2);
                s = fshr(s + 2, 2);
                r.axp_x = 32'(sat32(fshr(rx * c + 64'sh20000000, 30), sat));
                r.axp_y = 32'(sat32(fshr(rx * s + 64'sh20000000, 30), sat));
                r.ayp_x = 32'(sat32(fshr(-(ry * s) + 64'sh20000000, 30), sat));
                r.ayp_y = 32'(sat32(fshr(ry * c + 64'sh20000000, 30), sat));
            end
        end else if (q.op == OP_C2P) begin
            x = longint'(signed'(q.cx));
            y = longint'(signed'(q.cy));
            if (x != 0 || y != 0) begin
                z = 0;
                if (x < 0) begin
                    x = -x; y = -y; z = HALF_TURN;
                end
                x *= 65536;
                y *= 65536;
                for (int i = 0; i < NSTG; i++) begin
                    dx = fshr(y, i);
                    dy = fshr(x, i);
                    if (y >= 0) begin
                        x += dx; y -= dy; z += atan_turn(i);
                    end else begin
                        x -= dx; y += dy; z -= atan_turn(i);
                    end
                end
                r.ang_out = 16'((z + 32'h8000) >> 16);
                ux = (x > 0) ? 64'(x) : 64'd0;
                t = (ux >> 32) * 64'(KINV) + (((ux & 64'hFFFFFFFF) * 64'(KINV)) >> 32);
                m = (t + 64'h8000) >> 16;
                if (m > 64'hFFFFFFFF) begin
                    m = 64'hFFFFFFFF;
                    sat = 1;
                end
                r.mod_out = m[31:0];
            end
        end
        r.sat = sat;
        return r;
    endfunction

    // saturated flag on top, then the tdata image
    function automatic logic [240:0] pack_res(geo_res_t r);
        return {r.sat, r.mod_out, r.ang_out, r.ayp_y, r.ayp_x,
                r.axp_y, r.axp_x, r.rot_y, r.rot_x};
    endfunction

    // ------------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        geo_res_t exp_r;
        logic [240:0] want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            n_results++;
            if (expected_q.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected result transfer %h %h", m_axis_tuser,
                             m_axis_tdata);
            end else begin
                exp_r = expected_q.pop_front();
                want = pack_res(exp_r);
                if ({m_axis_tuser, m_axis_tdata} !== want) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("mismatch #%0d: exp %h got %h", n_results, want,
                                 {m_axis_tuser, m_axis_tdata});
                end
            end
        end
    end

    // receiver: random stall, or a long hold-off counted here
    always @(posedge aclk) begin
        if (!aresetn)
            m_axis_tready <= 1'b0;
        else if (hold_cycles > 0) begin
            m_axis_tready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    // tvalid stays up between back-to-back transfers, drops only when idling
    task automatic send_req(geo_req_t q, bit has_res = 0, geo_res_t res = '0);
        while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tdata <= {q.fr, q.mag, q.ang, q.cy, q.cx};
        s_axis_tuser <= q.op;
        s_axis_tvalid <= 1'b1;
        expected_q.push_back(has_res ? res : predict_geometry(q));
        do @(posedge aclk); while (!s_axis_tready);
        n_sent++;
    endtask

    function automatic geo_req_t rand_req();
        geo_req_t q;
        q.op = ($urandom_range(19) == 0) ? OP_RSVD : 2'($urandom_range(2));
        q.cx = $urandom();
        q.cy = $urandom();
        q.ang = $urandom();
        q.fr = $urandom();
        // mostly modest magnitudes, sometimes huge to hit saturation
        case ($urandom_range(3))
            0: q.mag = $urandom();
            1: q.mag = $urandom_range(32'h00FFFFFF);
            default: q.mag = $urandom_range(32'h0FFFFFFF);
        endcase
        if ($urandom_range(3) == 0) begin
            q.cx = $signed(q.cx) >>> $urandom_range(31);
            q.cy = $signed(q.cy) >>> $urandom_range(31);
        end
        return q;
    endfunction

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge aclk);
    endtask

    vec_row_t vectors[$];

    initial begin
        geo_res_t zr;
        zr = '0;
        // zero vector, unused op code, then field extremes
        vectors.push_back('{'{OP_C2P, 32'd0, 32'd0, 16'hFFFF, 32'hFFFFFFFF, 16'hFFFF}, 1, zr});
        vectors.push_back('{'{OP_RSVD, '1, '1, '1, '1, '1}, 1, zr});
        vectors.push_back('{'{OP_P2C, '0, '0, 16'd0, 32'd0, 16'd0}, 1, zr});
        vectors.push_back('{'{OP_P2C, '0, '0, 16'h0000, 32'hFFFFFFFF, '0}, 0, zr});
        vectors.push_back('{'{OP_P2C, '0, '0, 16'h4000, 32'h00010000, '0}, 0, zr});
        vectors.push_back('{'{OP_P2C, '0, '0, 16'h8000, 32'hFFFFFFFF, '0}, 0, zr});
        vectors.push_back('{'{OP_P2C, '0, '0, 16'hC000, 32'h00010000, '0}, 0, zr});
        vectors.push_back('{'{OP_P2C, '0, '0, 16'hFFFF, 32'h7FFFFFFF, '0}, 0, zr});
        vectors.push_back('{'{OP_C2P, 32'h7FFFFFFF, 32'h7FFFFFFF, '0, '0, '0}, 0, zr});
        vectors.push_back('{'{OP_C2P, 32'h80000000, 32'h80000000, '0, '0, '0}, 0, zr});
        vectors.push_back('{'{OP_C2P, 32'h80000000, 32'h00000000, '0, '0, '0}, 0, zr});
        vectors.push_back('{'{OP_C2P, 32'h00000000, 32'h80000000, '0, '0, '0}, 0, zr});
        vectors.push_back('{'{OP_C2P, 32'h00010000, 32'hFFFFFFFF, '0, '0, '0}, 0, zr});
        vectors.push_back('{'{OP_C2P, 32'hFFFF0000, 32'h00000001, '0, '0, '0}, 0, zr});
        vectors.push_back('{'{OP_PROJ, '0, '0, 16'h2000, 32'h00010000, 16'h2000}, 0, zr});
        vectors.push_back('{'{OP_PROJ, '0, '0, 16'h0000, 32'hFFFFFFFF, 16'hFFFF}, 0, zr});
        vectors.push_back('{'{OP_PROJ, '0, '0, 16'hFFFF, 32'h80000000, 16'h8000}, 0, zr});
        vectors.push_back('{'{OP_PROJ, '0, '0, 16'h1234, 32'h00000000, 16'h4000}, 1, zr});

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (vectors[i])
            send_req(vectors[i].req, vectors[i].has_res, vectors[i].res);

        // random phases: free, sender idle, receiver stall, both
        for (int ph = 0; ph < 4; ph++) begin
            sender_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 17 : 79) : 0;
            recv_stall_pct = (ph == 2) ? 79 : ((ph == 3) ? 17 : 0);
            if (ph == 1) begin
                // long hold-off while traffic keeps coming: pipe fills
                hold_cycles = 200;
            end
            for (int n = 0; n < 500; n++)
                send_req(rand_req());
            if (ph == 2)
                drain();  // sender pause until everything is back
        end

        drain();
        repeat (LATENCY + 10) @(posedge aclk);
        $display("covered %0d transfers in, %0d results checked, 3 ops plus unused code",
                 n_sent, n_results);
        $display("phases: free flow, idle sender, stalled receiver, mixed, long hold-off");
        if (n_mismatch == 0 && expected_q.size() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    // run limit
    initial begin
        #4ms;
        $display("timeout");
        $display("testbench: done, errors");
        $finish;
    end

endmodule
